FILE: design/pending_request_table_defines.svh
// Assertion macros for the pending request table checker.
`ifndef PENDING_REQUEST_TABLE_DEFINES_SVH
`define PENDING_REQUEST_TABLE_DEFINES_SVH

// The consequence holds in the same cycle as the antecedent.
`define PRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define PRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/prt_pkg.sv
`default_nettype none

package prt_pkg;

    // Default sizes of the table.
    localparam int MAX_BUCKETS_DEF      = 1024;
    localparam int SLOTS_PER_BUCKET_DEF = 8;
    localparam int RING_SLOTS_DEF       = 1024;
    localparam int NAME_BYTES_DEF       = 64;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [10:0] BUCKET_COUNT_RST   = 11'd1024;
    localparam logic [9:0]  RING_LIMIT_RST     = 10'd1023;
    localparam logic [31:0] ENTRY_LIFETIME_RST = 32'd1000000;

    // Remainder unit widths.
    localparam int DIVIDEND_W = 32;
    localparam int DIV_W      = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BUCKET_COUNT   = 2'd0,
        CFG_RING_LIMIT     = 2'd1,
        CFG_ENTRY_LIFETIME = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        FUNC_LOAD   = 3'd0,
        FUNC_UPDATE = 3'd1,
        FUNC_REMOVE = 3'd2,
        FUNC_PURGE  = 3'd3,
        FUNC_LOOKUP = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        STATUS_LOADED     = 3'd0,
        STATUS_MERGED     = 3'd1,
        STATUS_INSERTED   = 3'd2,
        STATUS_NO_SPACE   = 3'd3,
        STATUS_REMOVED    = 3'd4,
        STATUS_NOT_FOUND  = 3'd5,
        STATUS_FOUND      = 3'd6,
        STATUS_PURGE_DONE = 3'd7
    } t_status;

    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  name_pos;
        logic [7:0]  name_byte;
        logic [6:0]  name_length;
        logic [31:0] name_hash;
        logic [5:0]  face_id;
        logic [63:0] now;
    } t_prt_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] face_mask;
        logic [10:0] purged_count;
    } t_prt_out;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIV_W-1:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SLOT_RD,
        S_SLOT_CK,
        S_ENT_RD,
        S_ENT_CK,
        S_BYTE_RD,
        S_BYTE_CK,
        S_HIT_RD,
        S_HIT_ACT,
        S_MISS,
        S_HNEXT,
        S_HDIV,
        S_INSERT,
        S_CPY_RD,
        S_CPY_WR,
        S_TNEXT,
        S_TDIV,
        S_PURGE,
        S_PG_EVAL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: design/prt_divmod.sv
`default_nettype none

// Restoring remainder unit: one quotient bit per cycle.
module prt_divmod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire prt_pkg::t_div_req i_req,
    output prt_pkg::t_div_rsp      o_rsp
);

    localparam int NW = prt_pkg::DIVIDEND_W;
    localparam int DW = prt_pkg::DIV_W;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [DW:0]   shifted;
    logic [DW:0]   n_rem;

    always_comb begin
        shifted = {r_rem, r_num[NW-1]};
        if (shifted >= {1'b0, r_den}) begin
            n_rem = shifted - {1'b0, r_den};
        end else begin
            n_rem = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem[DW-1:0];
                r_num <= r_num << 1;
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

FILE: design/pending_request_table.sv
`default_nettype none

// Channel   Direction  Beat type   Handshake
// in        input      t_prt_in    i_in_valid / o_in_ready
// out       output     t_prt_out   o_out_valid / i_out_ready
// cfg       input      32-bit data i_cfg_we, i_cfg_index (no wait)
//
// A lookup, update or remove first works out the bucket on the serial remainder unit,
// then reads and checks each bucket slot in turn, the entry header and each compared
// name byte; an insert then copies the name bytes one by one. Purge steps over the
// ring positions one at a time. After reset a clearing pass over max(slots, ring)
// addresses (8192 at default sizes) runs with o_in_ready low; configuration writes
// are still taken. A finished beat waits in the output register while the next one
// is worked.

module pending_request_table #(
    parameter int MAX_BUCKETS      = prt_pkg::MAX_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = prt_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int RING_SLOTS       = prt_pkg::RING_SLOTS_DEF,
    parameter int NAME_BYTES       = prt_pkg::NAME_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire prt_pkg::t_prt_in                 i_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output prt_pkg::t_prt_out                     o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [prt_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [prt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int TABLE_SLOTS = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int BKW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int TIW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int RIW   = $clog2(RING_SLOTS);
    localparam int RMW   = RIW + 1;
    localparam int NIW   = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int LW    = $clog2(NAME_BYTES + 1);
    localparam int NBAW  = $clog2(RING_SLOTS * NAME_BYTES);
    localparam int STW   = $clog2(RING_SLOTS + 1);
    localparam int CLR_N = (TABLE_SLOTS > RING_SLOTS) ? TABLE_SLOTS : RING_SLOTS;
    localparam int CLW   = $clog2(CLR_N);
    localparam int DVW   = prt_pkg::DIV_W;

    // A busy slot keeps the name hash and the ring entry it points to.
    typedef struct packed {
        logic [31:0]    hash;
        logic [RIW-1:0] ring_index;
    } t_sdat;

    // Ring entry header.
    typedef struct packed {
        logic [TIW-1:0] home;
        logic [63:0]    expiry;
        logic [LW-1:0]  name_length;
    } t_edat;

    // Configuration registers.
    logic [10:0] r_bucket_count;
    logic [9:0]  r_ring_limit;
    logic [31:0] r_entry_lifetime;

    // Sequencer and datapath registers.
    prt_pkg::t_state   r_state;
    prt_pkg::t_state   n_state;
    prt_pkg::t_prt_in  r_req;
    prt_pkg::t_prt_out r_res;
    prt_pkg::t_prt_out r_obeat;
    logic              r_ovld;
    logic [BKW-1:0]    r_bucket;
    logic [SW-1:0]     r_slot;
    logic [TIW-1:0]    r_tcur;
    logic              r_free_vld;
    logic [TIW-1:0]    r_free_t;
    logic [RIW-1:0]    r_esel;
    logic [NIW-1:0]    r_idx;
    logic [RIW-1:0]    r_head;
    logic [RIW-1:0]    r_tail;
    logic [RIW-1:0]    r_nidx;
    logic [STW-1:0]    r_steps;
    logic [CLW-1:0]    r_clr;

    // Memories and their registered read data.
    logic [7:0]  nbuf_mem  [NAME_BYTES];
    logic        busy_mem  [TABLE_SLOTS];
    t_sdat       sdat_mem  [TABLE_SLOTS];
    logic        act_mem   [RING_SLOTS];
    t_edat       edat_mem  [RING_SLOTS];
    logic [63:0] face_mem  [RING_SLOTS];
    logic [7:0]  nbyte_mem [RING_SLOTS * NAME_BYTES];

    logic [7:0]  r_nbuf_rd;
    logic        r_busy_rd;
    t_sdat       r_sdat_rd;
    logic        r_act_rd;
    t_edat       r_edat_rd;
    logic [63:0] r_face_rd;
    logic [7:0]  r_nbyte_rd;

    // Memory controls.
    logic            nbuf_we;
    logic [NIW-1:0]  nbuf_wa;
    logic            busy_we;
    logic [TIW-1:0]  busy_wa;
    logic            busy_wd;
    logic            sdat_we;
    t_sdat           sdat_wd;
    logic            act_we;
    logic [RIW-1:0]  act_wa;
    logic            act_wd;
    logic            edat_we;
    t_edat           edat_wd;
    logic            face_we;
    logic [RIW-1:0]  face_wa;
    logic [63:0]     face_wd;
    logic            nbyte_we;
    logic [RIW-1:0]  ring_ra;
    logic [NBAW-1:0] nbyte_a;
    logic            slot_next;

    // Shared remainder unit.
    prt_pkg::t_div_req div_req;
    prt_pkg::t_div_rsp div_rsp;

    // Derived values.
    logic           accept;
    logic [DVW-1:0] eff_buckets;
    logic [RMW-1:0] ring_m;
    logic [LW-1:0]  clen;
    logic [TIW-1:0] cur_t;
    logic           slot_last;
    logic           idx_last;
    logic           cand;
    logic           expired;
    logic [RMW-1:0] head_inc;
    logic [RMW-1:0] tail_inc;
    logic [RIW-1:0] head_fast;
    logic [RIW-1:0] tail_fast;
    logic [63:0]    face_bit;
    logic [31:0]    rlim;

    assign o_in_ready  = (r_state == prt_pkg::S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovld;
    assign o_out       = r_obeat;

    // A bucket count of zero acts as one, and one above MAX_BUCKETS as MAX_BUCKETS.
    always_comb begin
        if (r_bucket_count == '0) begin
            eff_buckets = DVW'(1);
        end else if (32'(r_bucket_count) > 32'(MAX_BUCKETS)) begin
            eff_buckets = DVW'(MAX_BUCKETS);
        end else begin
            eff_buckets = DVW'(r_bucket_count);
        end
    end

    // The ring uses one position more than the live entry limit.
    always_comb begin
        if (r_ring_limit == '0) begin
            rlim = 32'd1;
        end else if (32'(r_ring_limit) > 32'(RING_SLOTS - 1)) begin
            rlim = 32'(RING_SLOTS - 1);
        end else begin
            rlim = 32'(r_ring_limit);
        end
        ring_m = RMW'(rlim + 32'd1);
    end

    // Names longer than the buffer are cut to the buffer length.
    always_comb begin
        if (32'(r_req.name_length) > 32'(NAME_BYTES)) begin
            clen = LW'(NAME_BYTES);
        end else begin
            clen = LW'(r_req.name_length);
        end
    end

    assign cur_t     = TIW'(32'(r_bucket) * 32'(SLOTS_PER_BUCKET) + 32'(r_slot));
    assign slot_last = (r_slot == SW'(SLOTS_PER_BUCKET - 1));
    assign idx_last  = (32'(r_idx) == 32'(clen) - 32'd1);
    assign cand      = r_busy_rd && (r_sdat_rd.hash == r_req.name_hash);
    assign expired   = !(r_edat_rd.expiry > r_req.now);
    assign face_bit  = 64'(1) << r_req.face_id;
    assign nbyte_a   = NBAW'(32'(r_esel) * 32'(NAME_BYTES) + 32'(r_idx));

    // Ring index advance. The slow path only arises when the ring limit was lowered
    // below a live head or tail index.
    assign head_inc  = RMW'(r_head) + RMW'(1);
    assign tail_inc  = RMW'(r_tail) + RMW'(1);
    assign head_fast = (head_inc == ring_m) ? '0 : RIW'(head_inc);
    assign tail_fast = (tail_inc == ring_m) ? '0 : RIW'(tail_inc);

    prt_divmod u_divmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count   <= prt_pkg::BUCKET_COUNT_RST;
            r_ring_limit     <= prt_pkg::RING_LIMIT_RST;
            r_entry_lifetime <= prt_pkg::ENTRY_LIFETIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                prt_pkg::CFG_BUCKET_COUNT:   r_bucket_count   <= i_cfg_data[10:0];
                prt_pkg::CFG_RING_LIMIT:     r_ring_limit     <= i_cfg_data[9:0];
                prt_pkg::CFG_ENTRY_LIFETIME: r_entry_lifetime <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            prt_pkg::S_CLEAR: begin
                if (r_clr == CLW'(CLR_N - 1)) n_state = prt_pkg::S_IDLE;
            end
            prt_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_in.func)
                        prt_pkg::FUNC_UPDATE, prt_pkg::FUNC_REMOVE,
                        prt_pkg::FUNC_LOOKUP: n_state = prt_pkg::S_DIV;
                        prt_pkg::FUNC_PURGE:  n_state = prt_pkg::S_PURGE;
                        default:              n_state = prt_pkg::S_DONE;
                    endcase
                end
            end
            prt_pkg::S_DIV: begin
                if (div_rsp.done) n_state = prt_pkg::S_SLOT_RD;
            end
            prt_pkg::S_SLOT_RD: n_state = prt_pkg::S_SLOT_CK;
            prt_pkg::S_SLOT_CK: begin
                if (cand) begin
                    n_state = prt_pkg::S_ENT_RD;
                end else begin
                    n_state = slot_last ? prt_pkg::S_MISS : prt_pkg::S_SLOT_RD;
                end
            end
            prt_pkg::S_ENT_RD: n_state = prt_pkg::S_ENT_CK;
            prt_pkg::S_ENT_CK: begin
                if (r_edat_rd.name_length != clen) begin
                    n_state = slot_last ? prt_pkg::S_MISS : prt_pkg::S_SLOT_RD;
                end else if (clen == '0) begin
                    n_state = prt_pkg::S_HIT_RD;
                end else begin
                    n_state = prt_pkg::S_BYTE_RD;
                end
            end
            prt_pkg::S_BYTE_RD: n_state = prt_pkg::S_BYTE_CK;
            prt_pkg::S_BYTE_CK: begin
                if (r_nbuf_rd != r_nbyte_rd) begin
                    n_state = slot_last ? prt_pkg::S_MISS : prt_pkg::S_SLOT_RD;
                end else if (idx_last) begin
                    n_state = prt_pkg::S_HIT_RD;
                end else begin
                    n_state = prt_pkg::S_BYTE_RD;
                end
            end
            prt_pkg::S_HIT_RD: n_state = prt_pkg::S_HIT_ACT;
            prt_pkg::S_HIT_ACT: begin
                if (r_req.func == prt_pkg::FUNC_REMOVE && r_tail == r_esel) begin
                    n_state = prt_pkg::S_TNEXT;
                end else begin
                    n_state = prt_pkg::S_DONE;
                end
            end
            prt_pkg::S_MISS: begin
                if (r_req.func == prt_pkg::FUNC_UPDATE && r_free_vld) begin
                    n_state = prt_pkg::S_HNEXT;
                end else begin
                    n_state = prt_pkg::S_DONE;
                end
            end
            prt_pkg::S_HNEXT: begin
                n_state = (head_inc > ring_m) ? prt_pkg::S_HDIV : prt_pkg::S_INSERT;
            end
            prt_pkg::S_HDIV: begin
                if (div_rsp.done) n_state = prt_pkg::S_INSERT;
            end
            prt_pkg::S_INSERT: begin
                if (r_nidx == r_tail || clen == '0) begin
                    n_state = prt_pkg::S_DONE;
                end else begin
                    n_state = prt_pkg::S_CPY_RD;
                end
            end
            prt_pkg::S_CPY_RD: n_state = prt_pkg::S_CPY_WR;
            prt_pkg::S_CPY_WR: begin
                n_state = idx_last ? prt_pkg::S_DONE : prt_pkg::S_CPY_RD;
            end
            prt_pkg::S_TNEXT: begin
                if (tail_inc > ring_m) begin
                    n_state = prt_pkg::S_TDIV;
                end else if (r_req.func == prt_pkg::FUNC_PURGE) begin
                    n_state = prt_pkg::S_PURGE;
                end else begin
                    n_state = prt_pkg::S_DONE;
                end
            end
            prt_pkg::S_TDIV: begin
                if (div_rsp.done) begin
                    if (r_req.func == prt_pkg::FUNC_PURGE) begin
                        n_state = prt_pkg::S_PURGE;
                    end else begin
                        n_state = prt_pkg::S_DONE;
                    end
                end
            end
            prt_pkg::S_PURGE: begin
                if (r_tail == r_head || r_steps == STW'(RING_SLOTS)) begin
                    n_state = prt_pkg::S_DONE;
                end else begin
                    n_state = prt_pkg::S_PG_EVAL;
                end
            end
            prt_pkg::S_PG_EVAL: begin
                if (r_act_rd && !expired) begin
                    n_state = prt_pkg::S_DONE;
                end else begin
                    n_state = prt_pkg::S_TNEXT;
                end
            end
            prt_pkg::S_DONE: begin
                if (!r_ovld || i_out_ready) n_state = prt_pkg::S_IDLE;
            end
            default: n_state = prt_pkg::S_IDLE;
        endcase
    end

    // Memory and remainder unit controls.
    always_comb begin
        nbuf_we   = 1'b0;
        nbuf_wa   = NIW'(i_in.name_pos);
        busy_we   = 1'b0;
        busy_wa   = r_tcur;
        busy_wd   = 1'b0;
        sdat_we   = 1'b0;
        sdat_wd   = '{hash: r_req.name_hash, ring_index: r_head};
        act_we    = 1'b0;
        act_wa    = r_esel;
        act_wd    = 1'b0;
        edat_we   = 1'b0;
        edat_wd   = '{home: r_free_t,
                      expiry: r_req.now + 64'(r_entry_lifetime),
                      name_length: clen};
        face_we   = 1'b0;
        face_wa   = r_esel;
        face_wd   = r_face_rd | face_bit;
        nbyte_we  = 1'b0;
        ring_ra   = (r_state == prt_pkg::S_PURGE) ? r_tail : r_esel;
        slot_next = 1'b0;
        div_req   = '{start: 1'b0, dividend: i_in.name_hash, divisor: eff_buckets};
        case (r_state)
            prt_pkg::S_CLEAR: begin
                busy_we = (32'(r_clr) < 32'(TABLE_SLOTS));
                busy_wa = r_clr[TIW-1:0];
                act_we  = (32'(r_clr) < 32'(RING_SLOTS));
                act_wa  = r_clr[RIW-1:0];
            end
            prt_pkg::S_IDLE: begin
                if (accept) begin
                    nbuf_we = (i_in.func == prt_pkg::FUNC_LOAD) &&
                              (32'(i_in.name_pos) < 32'(NAME_BYTES));
                    div_req.start = (i_in.func == prt_pkg::FUNC_UPDATE) ||
                                    (i_in.func == prt_pkg::FUNC_REMOVE) ||
                                    (i_in.func == prt_pkg::FUNC_LOOKUP);
                end
            end
            prt_pkg::S_SLOT_CK: slot_next = !cand;
            prt_pkg::S_ENT_CK:  slot_next = (r_edat_rd.name_length != clen);
            prt_pkg::S_BYTE_CK: slot_next = (r_nbuf_rd != r_nbyte_rd);
            prt_pkg::S_HIT_ACT: begin
                if (r_req.func == prt_pkg::FUNC_UPDATE) begin
                    face_we = 1'b1;
                end
                if (r_req.func == prt_pkg::FUNC_REMOVE) begin
                    busy_we = 1'b1;
                    act_we  = 1'b1;
                end
            end
            prt_pkg::S_HNEXT: begin
                div_req = '{start: (head_inc > ring_m), dividend: 32'(head_inc),
                            divisor: DVW'(ring_m)};
            end
            prt_pkg::S_TNEXT: begin
                div_req = '{start: (tail_inc > ring_m), dividend: 32'(tail_inc),
                            divisor: DVW'(ring_m)};
            end
            prt_pkg::S_INSERT: begin
                if (r_nidx != r_tail) begin
                    busy_we = 1'b1;
                    busy_wa = r_free_t;
                    busy_wd = 1'b1;
                    sdat_we = 1'b1;
                    act_we  = 1'b1;
                    act_wa  = r_head;
                    act_wd  = 1'b1;
                    edat_we = 1'b1;
                    face_we = 1'b1;
                    face_wa = r_head;
                    face_wd = face_bit;
                end
            end
            prt_pkg::S_CPY_WR: nbyte_we = 1'b1;
            prt_pkg::S_PG_EVAL: begin
                if (r_act_rd && expired) begin
                    act_we  = 1'b1;
                    act_wa  = r_tail;
                    busy_we = 1'b1;
                    busy_wa = r_edat_rd.home;
                end
            end
            default: begin
            end
        endcase
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (nbuf_we) nbuf_mem[nbuf_wa] <= i_in.name_byte;
        r_nbuf_rd <= nbuf_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (busy_we) busy_mem[busy_wa] <= busy_wd;
        r_busy_rd <= busy_mem[cur_t];
    end

    always_ff @(posedge i_clk) begin
        if (sdat_we) sdat_mem[r_free_t] <= sdat_wd;
        r_sdat_rd <= sdat_mem[cur_t];
    end

    always_ff @(posedge i_clk) begin
        if (act_we) act_mem[act_wa] <= act_wd;
        r_act_rd <= act_mem[ring_ra];
    end

    always_ff @(posedge i_clk) begin
        if (edat_we) edat_mem[r_head] <= edat_wd;
        r_edat_rd <= edat_mem[ring_ra];
    end

    always_ff @(posedge i_clk) begin
        if (face_we) face_mem[face_wa] <= face_wd;
        r_face_rd <= face_mem[ring_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nbyte_we) nbyte_mem[nbyte_a] <= r_nbuf_rd;
        r_nbyte_rd <= nbyte_mem[nbyte_a];
    end

    // Sequencer registers and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prt_pkg::S_CLEAR;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            // In the done state the output register is refilled below instead.
            if (r_ovld && i_out_ready && r_state != prt_pkg::S_DONE) r_ovld <= 1'b0;
            if (slot_next) r_slot <= r_slot + SW'(1);
            case (r_state)
                prt_pkg::S_CLEAR: r_clr <= r_clr + CLW'(1);
                prt_pkg::S_IDLE: begin
                    if (accept) begin
                        r_req   <= i_in;
                        r_steps <= '0;
                        r_res   <= '{status: (i_in.func == prt_pkg::FUNC_LOAD) ?
                                             prt_pkg::STATUS_LOADED :
                                             prt_pkg::STATUS_NOT_FOUND,
                                     face_mask: '0, purged_count: '0};
                    end
                end
                prt_pkg::S_DIV: begin
                    if (div_rsp.done) begin
                        r_bucket   <= BKW'(div_rsp.rem);
                        r_slot     <= '0;
                        r_free_vld <= 1'b0;
                    end
                end
                prt_pkg::S_SLOT_CK: begin
                    if (!r_busy_rd && !r_free_vld) begin
                        r_free_vld <= 1'b1;
                        r_free_t   <= cur_t;
                    end
                    if (cand) begin
                        r_tcur <= cur_t;
                        r_esel <= r_sdat_rd.ring_index;
                    end
                end
                prt_pkg::S_ENT_CK: r_idx <= '0;
                prt_pkg::S_BYTE_CK: r_idx <= r_idx + NIW'(1);
                prt_pkg::S_HIT_ACT: begin
                    case (r_req.func)
                        prt_pkg::FUNC_UPDATE: r_res.status <= prt_pkg::STATUS_MERGED;
                        prt_pkg::FUNC_REMOVE: begin
                            r_res.status    <= prt_pkg::STATUS_REMOVED;
                            r_res.face_mask <= r_face_rd;
                        end
                        default: begin
                            r_res.status    <= prt_pkg::STATUS_FOUND;
                            r_res.face_mask <= r_face_rd;
                        end
                    endcase
                end
                prt_pkg::S_MISS: begin
                    if (r_req.func == prt_pkg::FUNC_UPDATE && !r_free_vld) begin
                        r_res.status <= prt_pkg::STATUS_NO_SPACE;
                    end
                end
                prt_pkg::S_HNEXT: r_nidx <= head_fast;
                prt_pkg::S_HDIV: begin
                    if (div_rsp.done) r_nidx <= RIW'(div_rsp.rem);
                end
                prt_pkg::S_INSERT: begin
                    if (r_nidx == r_tail) begin
                        r_res.status <= prt_pkg::STATUS_NO_SPACE;
                    end else begin
                        r_res.status <= prt_pkg::STATUS_INSERTED;
                        r_head       <= r_nidx;
                        r_esel       <= r_head;
                        r_idx        <= '0;
                    end
                end
                prt_pkg::S_CPY_WR: r_idx <= r_idx + NIW'(1);
                prt_pkg::S_TNEXT: begin
                    if (!(tail_inc > ring_m)) begin
                        r_tail  <= tail_fast;
                        r_steps <= r_steps + STW'(1);
                    end
                end
                prt_pkg::S_TDIV: begin
                    if (div_rsp.done) begin
                        r_tail  <= RIW'(div_rsp.rem);
                        r_steps <= r_steps + STW'(1);
                    end
                end
                prt_pkg::S_PURGE: begin
                    r_res.status       <= prt_pkg::STATUS_PURGE_DONE;
                    r_res.purged_count <= 11'(r_steps);
                end
                prt_pkg::S_DONE: begin
                    if (!r_ovld || i_out_ready) begin
                        r_obeat <= r_res;
                        r_ovld  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/prt_checker.sv
`default_nettype none

`include "pending_request_table_defines.svh"

module prt_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire prt_pkg::t_prt_out o_out
);

    logic out_stall;
    logic in_take;
    logic not_purge;
    logic no_mask;

    assign out_stall = o_out_valid && !i_out_ready;
    assign in_take   = i_in_valid && o_in_ready;
    assign not_purge = o_out_valid && (o_out.status != prt_pkg::STATUS_PURGE_DONE);
    assign no_mask   = o_out_valid && (o_out.status != prt_pkg::STATUS_REMOVED) &&
                       (o_out.status != prt_pkg::STATUS_FOUND);

    // A stalled result stays offered and unchanged.
    `PRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid, "out valid dropped")
    `PRT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(o_out), "out beat changed")

    // Every accepted request takes the sequencer out of idle, so input ready drops.
    `PRT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_take, !o_in_ready, "ready too soon")

    // Only purge reports stepped positions.
    `PRT_ASSERT_SAME(a_purged_zero, i_clk, i_rst_n, not_purge, o_out.purged_count == '0, "count")

    // Only removed and found results carry a mask.
    `PRT_ASSERT_SAME(a_mask_zero, i_clk, i_rst_n, no_mask, o_out.face_mask == '0, "mask")

endmodule

bind pending_request_table prt_checker u_prt_checker (.*);

`default_nettype wire

FILE: sim/tb_pending_request_table.sv
`timescale 1ns / 100ps

module tb_pending_request_table;

    localparam int BUCKET_SLOTS = prt_pkg::SLOTS_PER_BUCKET_DEF;
    localparam int TABLE_SIZE   = prt_pkg::MAX_BUCKETS_DEF * prt_pkg::SLOTS_PER_BUCKET_DEF;
    localparam int RING_SIZE    = prt_pkg::RING_SLOTS_DEF;
    localparam int NAME_MAX     = prt_pkg::NAME_BYTES_DEF;
    localparam int BEAT_TARGET  = 1600;
    localparam int PHASES       = 6;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    prt_pkg::t_prt_in  i_in        = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    prt_pkg::t_prt_out o_out;
    logic              i_cfg_we    = 1'b0;
    logic [prt_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [prt_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;

    pending_request_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the table, kept in step with every accepted request beat.
    int unsigned bucket_reg   = 1024;
    int unsigned ring_lim_reg = 1023;
    logic [31:0] lifetime_reg = 32'd1000000;

    logic [7:0]  name_buf   [NAME_MAX];
    bit          slot_used  [TABLE_SIZE];
    logic [31:0] slot_crc   [TABLE_SIZE];
    int unsigned slot_entry [TABLE_SIZE];
    bit          ent_live   [RING_SIZE];
    int unsigned ent_slot   [RING_SIZE];
    logic [63:0] ent_expiry [RING_SIZE];
    int unsigned ent_len    [RING_SIZE];
    logic [7:0]  ent_name   [RING_SIZE][NAME_MAX];
    logic [63:0] ent_faces  [RING_SIZE];
    int unsigned ring_wr    = 0;
    int unsigned ring_rd    = 0;

    // Responses still owed by the table, oldest first.
    prt_pkg::t_prt_out responses_owed[$];
    int          mismatches = 0;
    int          beats_sent = 0;
    int          send_idle  = 0;
    int          recv_idle  = 0;
    int          hold_left  = 0;
    int          status_seen[8];
    int          settings_run = 0;

    // Name pool used to build well-formed request sequences.
    int unsigned pool_len  [16];
    logic [31:0] pool_crc  [16];
    logic [7:0]  pool_name [16][NAME_MAX];
    logic [63:0] clock_now = 64'd0;

    function automatic int unsigned live_buckets();
        if (bucket_reg < 1) return 1;
        if (bucket_reg > prt_pkg::MAX_BUCKETS_DEF) return prt_pkg::MAX_BUCKETS_DEF;
        return bucket_reg;
    endfunction

    function automatic int unsigned ring_span();
        int unsigned r;
        r = ring_lim_reg;
        if (r < 1) r = 1;
        if (r > RING_SIZE - 1) r = RING_SIZE - 1;
        return r + 1;
    endfunction

    // Returns the table slot that holds this name, or -1.
    function automatic int match_slot(int unsigned bkt, logic [31:0] crc, int unsigned len);
        int unsigned t;
        int unsigned e;
        bit same;
        for (int s = 0; s < BUCKET_SLOTS; s++) begin
            t = bkt * BUCKET_SLOTS + s;
            if (!slot_used[t] || slot_crc[t] != crc) continue;
            e = slot_entry[t] % RING_SIZE;
            if (ent_len[e] != len) continue;
            same = 1'b1;
            for (int i = 0; i < len; i++) begin
                if (name_buf[i] != ent_name[e][i]) same = 1'b0;
            end
            if (same) return t;
        end
        return -1;
    endfunction

    function automatic prt_pkg::t_prt_out table_response(prt_pkg::t_prt_in b);
        prt_pkg::t_prt_out r;
        int unsigned len;
        int unsigned bkt;
        int unsigned m;
        int unsigned e;
        int unsigned t;
        int unsigned steps;
        int          hit;
        int          free_slot;
        len = (b.name_length > NAME_MAX) ? NAME_MAX : b.name_length;
        bkt = int'(b.name_hash % live_buckets());
        m   = ring_span();
        r   = '0;
        r.status = prt_pkg::STATUS_NOT_FOUND;
        case (b.func)
            prt_pkg::FUNC_LOAD: begin
                name_buf[b.name_pos] = b.name_byte;
                r.status = prt_pkg::STATUS_LOADED;
            end
            prt_pkg::FUNC_UPDATE: begin
                hit = match_slot(bkt, b.name_hash, len);
                if (hit >= 0) begin
                    e = slot_entry[hit] % RING_SIZE;
                    ent_faces[e] |= 64'd1 << b.face_id;
                    r.status = prt_pkg::STATUS_MERGED;
                end else begin
                    free_slot = -1;
                    for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
                        if (!slot_used[bkt * BUCKET_SLOTS + s]) free_slot = s;
                    end
                    if (free_slot < 0 || ((ring_wr + 1) % m) == ring_rd) begin
                        r.status = prt_pkg::STATUS_NO_SPACE;
                    end else begin
                        t = bkt * BUCKET_SLOTS + free_slot;
                        e = ring_wr % RING_SIZE;
                        slot_used[t]  = 1'b1;
                        slot_crc[t]   = b.name_hash;
                        slot_entry[t] = e;
                        ent_live[e]   = 1'b1;
                        ent_slot[e]   = t;
                        ent_expiry[e] = b.now + {32'd0, lifetime_reg};
                        ent_len[e]    = len;
                        for (int i = 0; i < len; i++) ent_name[e][i] = name_buf[i];
                        ent_faces[e]  = 64'd1 << b.face_id;
                        ring_wr = (ring_wr + 1) % m;
                        r.status = prt_pkg::STATUS_INSERTED;
                    end
                end
            end
            prt_pkg::FUNC_REMOVE: begin
                hit = match_slot(bkt, b.name_hash, len);
                if (hit >= 0) begin
                    e = slot_entry[hit] % RING_SIZE;
                    slot_used[hit] = 1'b0;
                    ent_live[e] = 1'b0;
                    if (ring_rd == e) ring_rd = (ring_rd + 1) % m;
                    r.face_mask = ent_faces[e];
                    r.status = prt_pkg::STATUS_REMOVED;
                end
            end
            prt_pkg::FUNC_PURGE: begin
                steps = 0;
                while (ring_rd != ring_wr && steps < RING_SIZE) begin
                    e = ring_rd % RING_SIZE;
                    if (ent_live[e]) begin
                        if (ent_expiry[e] > b.now) break;
                        ent_live[e] = 1'b0;
                        slot_used[ent_slot[e] % TABLE_SIZE] = 1'b0;
                    end
                    ring_rd = (ring_rd + 1) % m;
                    steps++;
                end
                r.purged_count = steps[10:0];
                r.status = prt_pkg::STATUS_PURGE_DONE;
            end
            prt_pkg::FUNC_LOOKUP: begin
                hit = match_slot(bkt, b.name_hash, len);
                if (hit >= 0) begin
                    r.face_mask = ent_faces[slot_entry[hit] % RING_SIZE];
                    r.status = prt_pkg::STATUS_FOUND;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Offers one request beat, holding it until the table takes it. Ready is sampled
    // at the falling edge, where it already shows the value seen by the next rising
    // edge. Valid is only lowered when an idle gap is wanted.
    task automatic offer_beat(prt_pkg::t_prt_in b, bit fixed, prt_pkg::t_prt_out fixed_res);
        prt_pkg::t_prt_out owed;
        bit                taken;
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= b;
        i_in_valid <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end
        owed = table_response(b);
        responses_owed.push_back(fixed ? fixed_res : owed);
        beats_sent++;
    endtask

    // Waits for every owed response, then keeps waiting so the table is idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (responses_owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Writes all three registers in turn and updates their shadow copies.
    task automatic write_settings(logic [31:0] buckets, logic [31:0] ring_lim,
                                  logic [31:0] lifetime);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= prt_pkg::CFG_BUCKET_COUNT;
        i_cfg_data  <= buckets;
        @(posedge i_clk);
        i_cfg_index <= prt_pkg::CFG_RING_LIMIT;
        i_cfg_data  <= ring_lim;
        @(posedge i_clk);
        i_cfg_index <= prt_pkg::CFG_ENTRY_LIFETIME;
        i_cfg_data  <= lifetime;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        bucket_reg   = buckets[10:0];
        ring_lim_reg = ring_lim[9:0];
        lifetime_reg = lifetime;
        settings_run++;
    endtask

    function automatic prt_pkg::t_prt_in make_beat(logic [2:0] func, logic [5:0] pos,
                                                   logic [7:0] data, logic [6:0] len,
                                                   logic [31:0] crc, logic [5:0] face,
                                                   logic [63:0] stamp);
        prt_pkg::t_prt_in b;
        b.func        = func;
        b.name_pos    = pos;
        b.name_byte   = data;
        b.name_length = len;
        b.name_hash   = crc;
        b.face_id     = face;
        b.now         = stamp;
        return b;
    endfunction

    function automatic prt_pkg::t_prt_out make_res(prt_pkg::t_status st, logic [63:0] mask,
                                                   logic [10:0] cnt);
        prt_pkg::t_prt_out r;
        r.status       = st;
        r.face_mask    = mask;
        r.purged_count = cnt;
        return r;
    endfunction

    function automatic prt_pkg::t_prt_in random_beat();
        return make_beat(3'($urandom_range(7)), 6'($urandom), 8'($urandom), 7'($urandom),
                         $urandom, 6'($urandom), {$urandom, $urandom});
    endfunction

    // Fresh names for a phase; some share a crc so collisions get exercised.
    task automatic refill_pool();
        for (int k = 0; k < 16; k++) begin
            case ($urandom_range(19))
                0:       pool_len[k] = $urandom_range(60, 64);
                1:       pool_len[k] = $urandom_range(65, 127);
                default: pool_len[k] = $urandom_range(0, 6);
            endcase
            pool_crc[k] = (k > 0 && $urandom_range(4) == 0) ? pool_crc[k-1] : $urandom;
            for (int i = 0; i < NAME_MAX; i++) pool_name[k][i] = 8'($urandom);
        end
    endtask

    // One well-formed sequence: load a pooled name, then act on it a few times.
    task automatic name_sequence();
        int unsigned      k;
        int unsigned      n;
        int unsigned      load_len;
        prt_pkg::t_prt_in b;
        k = $urandom_range(15);
        load_len = (pool_len[k] > NAME_MAX) ? NAME_MAX : pool_len[k];
        for (int i = 0; i < load_len; i++)
            offer_beat(make_beat(prt_pkg::FUNC_LOAD, 6'(i), pool_name[k][i], 0, 0, 0, 0),
                       1'b0, '0);
        n = $urandom_range(1, 6);
        repeat (n) begin
            clock_now += 64'($urandom_range(0, 60));
            b = make_beat(prt_pkg::FUNC_UPDATE, 6'($urandom), 8'($urandom),
                          7'(pool_len[k]), pool_crc[k], 6'($urandom), clock_now);
            case ($urandom_range(9))
                0, 1:    b.func = prt_pkg::FUNC_LOOKUP;
                2, 3:    b.func = prt_pkg::FUNC_REMOVE;
                4:       b.func = prt_pkg::FUNC_PURGE;
                default: ;
            endcase
            offer_beat(b, 1'b0, '0);
        end
    endtask

    // Response side: random backpressure, plus a long hold-off when asked for.
    // Outputs are sampled at the falling edge ahead of the accepting rising edge.
    initial begin : response_side
        prt_pkg::t_prt_out want;
        @(posedge i_rst_n);
        forever begin
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle);
            end
            @(negedge i_clk);
            if (o_out_valid && i_out_ready) begin
                status_seen[o_out.status]++;
                if (responses_owed.size() == 0) begin
                    flag_mismatch("unexpected beat", 64'(o_out.status), 64'd0);
                end else begin
                    want = responses_owed.pop_front();
                    if (o_out.status != want.status)
                        flag_mismatch("status", 64'(o_out.status), 64'(want.status));
                    if (o_out.face_mask != want.face_mask)
                        flag_mismatch("face_mask", o_out.face_mask, want.face_mask);
                    if (o_out.purged_count != want.purged_count)
                        flag_mismatch("purged_count", 64'(o_out.purged_count),
                                      64'(want.purged_count));
                end
            end
            @(posedge i_clk);
        end
    end

    initial begin : request_side
        prt_pkg::t_prt_in  dir_beat[$];
        bit                dir_fixed[$];
        prt_pkg::t_prt_out dir_res[$];
        int                phase_goal;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole name buffer so later compares never touch unloaded bytes.
        for (int i = 0; i < NAME_MAX; i++)
            offer_beat(make_beat(prt_pkg::FUNC_LOAD, 6'(i), 8'($urandom), 0, 0, 0, 0),
                       1'b0, '0);

        // Directed beats: empty-table misses, unknown functions, face extremes,
        // a long name that gets clamped, an expiry that wraps, purge and remove.
        dir_beat = '{
            make_beat(prt_pkg::FUNC_LOOKUP, 0, 0, 0, 32'h0, 0, 0),
            make_beat(prt_pkg::FUNC_REMOVE, 0, 0, 0, 32'h0, 0, 0),
            make_beat(prt_pkg::FUNC_PURGE, 0, 0, 0, 0, 0, 64'd0),
            make_beat(3'd5, 0, 0, 0, 0, 0, 0),
            make_beat(3'd6, 63, 8'hFF, 127, 32'hFFFF_FFFF, 63, '1),
            make_beat(3'd7, 0, 0, 0, 0, 0, 0),
            make_beat(prt_pkg::FUNC_LOAD, 63, 8'hFF, 0, 0, 0, 0),
            make_beat(prt_pkg::FUNC_UPDATE, 0, 0, 3, 32'hFFFF_FFFF, 63, 64'd0),
            make_beat(prt_pkg::FUNC_UPDATE, 0, 0, 3, 32'hFFFF_FFFF, 0, 64'd0),
            make_beat(prt_pkg::FUNC_UPDATE, 0, 0, 3, 32'hFFFF_FFFF, 0, 64'd0),
            make_beat(prt_pkg::FUNC_LOOKUP, 0, 0, 3, 32'hFFFF_FFFF, 0, 64'd0),
            make_beat(prt_pkg::FUNC_UPDATE, 0, 0, 100, 32'h0, 5, '1),
            make_beat(prt_pkg::FUNC_LOOKUP, 0, 0, 64, 32'h0, 0, 0),
            make_beat(prt_pkg::FUNC_PURGE, 0, 0, 0, 0, 0, 64'd2000000),
            make_beat(prt_pkg::FUNC_REMOVE, 0, 0, 3, 32'hFFFF_FFFF, 0, 0),
            make_beat(prt_pkg::FUNC_UPDATE, 0, 0, 0, 32'd123, 1, 64'd10),
            make_beat(prt_pkg::FUNC_REMOVE, 0, 0, 0, 32'd123, 0, 0),
            make_beat(prt_pkg::FUNC_LOAD, 0, 8'h00, 0, 0, 0, 0),
            make_beat(prt_pkg::FUNC_UPDATE, 0, 0, 127, 32'hA5A5_A5A5, 33, 64'd50),
            make_beat(prt_pkg::FUNC_LOOKUP, 0, 0, 64, 32'hA5A5_A5A5, 0, 0)
        };
        dir_fixed = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0};
        dir_res = '{
            make_res(prt_pkg::STATUS_NOT_FOUND, 0, 0),
            make_res(prt_pkg::STATUS_NOT_FOUND, 0, 0),
            make_res(prt_pkg::STATUS_PURGE_DONE, 0, 0),
            make_res(prt_pkg::STATUS_NOT_FOUND, 0, 0),
            make_res(prt_pkg::STATUS_NOT_FOUND, 0, 0),
            make_res(prt_pkg::STATUS_NOT_FOUND, 0, 0),
            make_res(prt_pkg::STATUS_LOADED, 0, 0),
            make_res(prt_pkg::STATUS_INSERTED, 0, 0),
            make_res(prt_pkg::STATUS_MERGED, 0, 0),
            make_res(prt_pkg::STATUS_MERGED, 0, 0),
            make_res(prt_pkg::STATUS_FOUND, 64'h8000_0000_0000_0001, 0),
            make_res(prt_pkg::STATUS_INSERTED, 0, 0),
            make_res(prt_pkg::STATUS_FOUND, 64'h20, 0),
            make_res(prt_pkg::STATUS_PURGE_DONE, 0, 2),
            make_res(prt_pkg::STATUS_NOT_FOUND, 0, 0),
            make_res(prt_pkg::STATUS_INSERTED, 0, 0),
            make_res(prt_pkg::STATUS_REMOVED, 64'h2, 0),
            '0, '0, '0
        };
        for (int r = 0; r < dir_beat.size(); r++)
            offer_beat(dir_beat[r], dir_fixed[r], dir_res[r]);

        // Random part: each phase has its own register setting and name pool.
        // The first two phases hold back the receiver most, the next two the sender,
        // and the last two run without idling.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: write_settings(32'd1024, 32'd1023, 32'd1000000);
                1: write_settings(32'd1, 32'd4, 32'd50);
                2: write_settings(32'd0, 32'd0, 32'd0);
                3: write_settings(32'd2047, 32'd1023, 32'hFFFF_FFFF);
                4: write_settings(32'd7, 32'd16, 32'd200);
                default: write_settings(32'd3, 32'd9, 32'd120);
            endcase
            send_idle = (p < 2) ? 13 : (p < 4) ? 49 : 0;
            recv_idle = (p < 2) ? 49 : (p < 4) ? 13 : 0;
            refill_pool();
            // The long hold-off backs results up until the table stalls its input.
            if (p == 0) hold_left = 3000;
            phase_goal = beats_sent + BEAT_TARGET / PHASES;
            while (beats_sent < phase_goal) begin
                if ($urandom_range(9) == 0) offer_beat(random_beat(), 1'b0, '0);
                else name_sequence();
            end
        end

        settle();
        $display("covered %0d beats under %0d register settings", beats_sent, settings_run);
        $display("inserts %0d, merges %0d, no space %0d, removes %0d, hits %0d, purges %0d",
                 status_seen[prt_pkg::STATUS_INSERTED], status_seen[prt_pkg::STATUS_MERGED],
                 status_seen[prt_pkg::STATUS_NO_SPACE], status_seen[prt_pkg::STATUS_REMOVED],
                 status_seen[prt_pkg::STATUS_FOUND], status_seen[prt_pkg::STATUS_PURGE_DONE]);
        if (mismatches == 0 && responses_owed.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Even a run made only of full purge walks and long-name updates under heavy
    // stalls stays far below this time limit.
    initial begin : watchdog
        #1_000_000_000;
        $display("timeout with %0d responses outstanding", responses_owed.size());
        $display("status: fail");
        $finish;
    end

endmodule

FILE: pending_request_table.f
+incdir+design
design/prt_pkg.sv
design/prt_divmod.sv
design/pending_request_table.sv
design/prt_checker.sv
sim/tb_pending_request_table.sv
